// ===== design/tri2d_pkg.sv =====
// ---------------------------------------------------------------------------
// tri2d_pkg
// Types, constants and register indexes shared by the 2-D trilateration block.
// ---------------------------------------------------------------------------
package tri2d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int REG_W          = 16;
  localparam int IDX_W          = 3;
  localparam int NUM_REGS       = 6;

  localparam logic [IDX_W-1:0] REG_AX = 3'd0;
  localparam logic [IDX_W-1:0] REG_AY = 3'd1;
  localparam logic [IDX_W-1:0] REG_BX = 3'd2;
  localparam logic [IDX_W-1:0] REG_BY = 3'd3;
  localparam logic [IDX_W-1:0] REG_CX = 3'd4;
  localparam logic [IDX_W-1:0] REG_CY = 3'd5;

  typedef struct packed {
    logic [15:0] range_to_a;
    logic [15:0] range_to_b;
    logic [15:0] range_to_c;
  } tri_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               x_failed;
    logic               y_failed;
  } tri_out_t;

  // numerator/denominator widths (bounded for COORD_BITS <= 20)
  localparam int NUM_W = 128;
  localparam int DEN_W = 72;
  localparam int CNT_W = 8;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_job_t;

endpackage

// ===== design/tri2d_div.sv =====
// ---------------------------------------------------------------------------
// tri2d_div
// Sequential signed divider: trunc(num*2^FRAC/den), saturated to 32 bits.
// One quotient bit per cycle, restoring.
// ---------------------------------------------------------------------------
module tri2d_div import tri2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  div_job_t           job,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quot
);
  localparam int SH_W = NUM_W + 16;

  logic [SH_W-1:0]  n;
  logic [DEN_W:0]   r;
  logic [DEN_W-1:0] dm;
  logic [CNT_W:0]   cnt;
  logic             neg;
  logic [DEN_W:0]   r_sh;
  logic [DEN_W:0]   r_sub;
  logic [NUM_W-1:0] nmag;
  logic [SH_W-1:0]  q;

  assign nmag  = job.num[NUM_W-1] ? NUM_W'(-job.num) : NUM_W'(job.num);
  assign r_sh  = {r[DEN_W-1:0], n[SH_W-1]};
  assign r_sub = r_sh - {1'b0, dm};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      n    <= SH_W'(nmag) << FRAC_BITS;
      dm   <= job.den[DEN_W-1] ? DEN_W'(-job.den) : DEN_W'(job.den);
      neg  <= job.num[NUM_W-1] ^ job.den[DEN_W-1];
      r    <= '0;
      q    <= '0;
      cnt  <= (CNT_W+1)'(SH_W);
    end else if (busy) begin
      n <= n << 1;
      if (!r_sub[DEN_W]) begin
        r <= r_sub;
        q <= {q[SH_W-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[SH_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == (CNT_W+1)'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (q > SH_W'(64'h8000_0000)) quot = 32'sh8000_0000;
      else quot = 32'(-q[31:0]);
    end else begin
      if (q > SH_W'(64'h7FFF_FFFF)) quot = 32'sh7FFF_FFFF;
      else quot = q[31:0];
    end
  end
endmodule

// ===== design/tri2d_front.sv =====
// ---------------------------------------------------------------------------
// tri2d_front
// Forms the exact numerators and denominators for one fix and classifies
// the degenerate geometries. Five register stages.
// ---------------------------------------------------------------------------
module tri2d_front import tri2d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tri_in_t          item,
  input  logic [REG_W-1:0] regs [NUM_REGS],
  output logic             out_valid,
  output div_job_t         job_y,
  output div_job_t         job_x,
  output logic             xf,
  output logic             yf
);
  localparam int E  = COORD_BITS + 1;      // coordinates, ranges, differences
  localparam int PW = 2 * E;               // squares and difference products
  localparam int TW = PW + 1;              // t2, s2, d
  localparam int YW = TW + E;              // y numerator partial products
  localparam int NW = YW + 1;              // y numerator, 2*d*dba
  localparam int MW = NW + E;              // x numerator partial products

  function automatic logic signed [E-1:0] sx(input logic [REG_W-1:0] v);
    return E'(signed'(COORD_BITS'(v)));
  endfunction
  function automatic logic signed [E-1:0] ux(input logic [15:0] v);
    return signed'({1'b0, COORD_BITS'(v)});
  endfunction
  function automatic logic signed [PW-1:0] sq(input logic signed [E-1:0] v);
    return v * v;
  endfunction

  // stage 1: squares and differences
  logic v1;
  logic signed [TW-1:0] s_t1, s_c, s_a;
  logic signed [PW-1:0] rc2, ra2;
  logic signed [E-1:0]  dab, dbc, dba, dcb;
  // stage 2
  logic v2;
  logic signed [TW-1:0] t2, s2;
  logic signed [PW-1:0] p1, p2;
  logic signed [E-1:0]  dab2, dbc2, dba2;
  // stage 3
  logic v3;
  logic signed [TW-1:0] d, t2_3;
  logic signed [YW-1:0] ny_a, ny_b;
  logic signed [E-1:0]  dab3, dba3;
  // stage 4
  logic v4;
  logic signed [NW-1:0] ny;
  logic signed [TW-1:0] d4, t2_4;
  logic signed [E-1:0]  dab4, dba4;
  // stage 5: x numerator products
  logic signed [MW-1:0] m1, m2;
  logic signed [NW-1:0] d2dba;
  div_job_t             jxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s_t1 <= sq(ux(item.range_to_b)) - sq(sx(regs[REG_BX])) - sq(sx(regs[REG_BY]));
    s_c  <= sq(sx(regs[REG_CX])) + sq(sx(regs[REG_CY]));
    s_a  <= sq(sx(regs[REG_AX])) + sq(sx(regs[REG_AY]));
    rc2  <= sq(ux(item.range_to_c));
    ra2  <= sq(ux(item.range_to_a));
    dab  <= sx(regs[REG_AY]) - sx(regs[REG_BY]);
    dbc  <= sx(regs[REG_BX]) - sx(regs[REG_CX]);
    dba  <= sx(regs[REG_BX]) - sx(regs[REG_AX]);
    dcb  <= sx(regs[REG_CY]) - sx(regs[REG_BY]);

    t2   <= s_a + s_t1 - ra2;
    s2   <= s_c + s_t1 - rc2;
    p1   <= dab * dbc;
    p2   <= dcb * dba;
    dab2 <= dab; dbc2 <= dbc; dba2 <= dba;

    d    <= p1 - p2;
    ny_a <= t2 * dbc2;
    ny_b <= s2 * dba2;
    t2_3 <= t2; dab3 <= dab2; dba3 <= dba2;

    ny   <= ny_a - ny_b;
    d4   <= d;
    t2_4 <= t2_3; dab4 <= dab3; dba4 <= dba3;
  end

  always_ff @(posedge clk) begin
    m1        <= ny * dab4;
    m2        <= t2_4 * d4;
    d2dba     <= (d4 * dba4) <<< 1;
    yf        <= (d4 == '0);
    xf        <= (dba4 == '0);
    job_y.num <= NUM_W'(ny);
    job_y.den <= DEN_W'(d4) <<< 1;
    // zero y denominator: x from y = -1 over 2*dba
    jxd.num   <= NUM_W'(-(dab4 <<< 1) - t2_4);
    jxd.den   <= DEN_W'(dba4) <<< 1;
  end

  always_comb begin
    if (yf) begin
      job_x = jxd;
    end else begin
      job_x.num = NUM_W'(m1) - NUM_W'(m2);
      job_x.den = DEN_W'(d2dba);
    end
  end
endmodule

// ===== design/trilateration_2d_solver.sv =====
// ---------------------------------------------------------------------------
// trilateration_2d_solver
// Each fix passes the front pipeline and the queue, then the shared divider
// forms its y quotient and then its x quotient before the strobe. The
// divider serves one fix at a time; a second fix is accepted while one is in
// flight, busy is high while two are, and a 2-entry queue decouples front/back.
// Reset (rst, synchronous) clears anchors to 0 and empties the pipeline.
// Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module trilateration_2d_solver import tri2d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tri_in_t          item,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output logic             strobe,
  output tri_out_t         result
);
  logic [REG_W-1:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (cfg_we && cfg_index < IDX_W'(NUM_REGS)) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  logic     fv, fxf, fyf;
  div_job_t fjy, fjx;
  logic     acc;
  assign acc = start && !busy;

  tri2d_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid(acc), .item, .regs,
    .out_valid(fv), .job_y(fjy), .job_x(fjx), .xf(fxf), .yf(fyf)
  );

  logic [2:0] in_flight;

  // simple queue depth 2
  div_job_t qy [2], qx [2];
  logic     qxf [2], qyf [2];
  logic [1:0] qcnt;
  logic       qrd, qwp, qrp;

  // back end state
  localparam logic [1:0] B_IDLE = 2'd0, B_Y = 2'd1, B_X = 2'd2;
  logic [1:0] bst;
  logic       dstart, dbusy, ddone;
  div_job_t   djob;
  logic signed [31:0] dq, ysave;
  logic       cxf, cyf;
  div_job_t   cjx;

  tri2d_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .start(dstart), .job(djob), .busy(dbusy), .done(ddone), .quot(dq)
  );

  assign qrd = (bst == B_IDLE) && (qcnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0; qwp <= 1'b0; qrp <= 1'b0; bst <= B_IDLE; strobe <= 1'b0;
      in_flight <= '0;
    end else begin
      strobe <= 1'b0;
      if (fv) begin
        qy[qwp] <= fjy; qx[qwp] <= fjx; qxf[qwp] <= fxf; qyf[qwp] <= fyf;
        qwp <= ~qwp;
      end
      qcnt <= qcnt + {1'b0, fv} - {1'b0, qrd};
      if (qrd) qrp <= ~qrp;
      in_flight <= in_flight + {2'b0, acc} - {2'b0, strobe};
      case (bst)
        B_IDLE: if (qrd) begin
          cjx <= qx[qrp]; cxf <= qxf[qrp]; cyf <= qyf[qrp];
          bst <= B_Y;
        end
        B_Y: if (ddone) begin
          ysave <= cyf ? -(32'sd1 <<< FRAC_BITS) : dq;
          bst <= B_X;
        end
        B_X: if (ddone) begin
          result.pos_x <= cxf ? -(32'sd1 <<< FRAC_BITS) : dq;
          result.pos_y <= ysave;
          result.x_failed <= cxf; result.y_failed <= cyf;
          strobe <= 1'b1;
          bst <= B_IDLE;
        end
        default: bst <= B_IDLE;
      endcase
    end
  end

  logic issued;
  always_ff @(posedge clk) begin
    if (rst) issued <= 1'b0;
    else if (dstart) issued <= 1'b1;
    else if (ddone) issued <= 1'b0;
  end

  always_comb begin
    dstart = 1'b0;
    djob   = cjx;
    if (bst == B_Y && !dbusy && !issued && !ddone) begin
      dstart = 1'b1; djob = qy[~qrp];
      if (djob.den == '0) djob.den = DEN_W'(1);
    end else if (bst == B_X && !dbusy && !issued && !ddone) begin
      dstart = 1'b1; djob = cjx;
      if (djob.den == '0) djob.den = DEN_W'(1);
    end
  end

  assign busy = (in_flight >= 3'd2);
endmodule

// ===== design/tri2d_checker.sv =====
// ---------------------------------------------------------------------------
// tri2d_checker
// Port-level checks on the trilateration block.
// ---------------------------------------------------------------------------
module tri2d_checker import tri2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     strobe,
  input tri_out_t result
);
  a_no_strobe_rst: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");
  a_idle_rst: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a start");
  a_xf_val: assert property (@(posedge clk) disable iff (rst)
    strobe && result.x_failed |-> result.pos_x == -(32'sd1 <<< FRAC_BITS))
    else $error("x fail value");
  a_yf_val: assert property (@(posedge clk) disable iff (rst)
    strobe && result.y_failed |-> result.pos_y == -(32'sd1 <<< FRAC_BITS))
    else $error("y fail value");
endmodule

bind trilateration_2d_solver tri2d_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
  .clk, .rst, .start, .busy, .strobe, .result
);

// ===== tb/tb_trilateration_2d_solver.sv =====
// ---------------------------------------------------------------------------
// tb_trilateration_2d_solver
// Regression for the 2-D trilateration block: anchors are loaded through the
// register port, ranges are sent as commands, and each strobed fix is checked
// against an exact-integer predictor (wide products, truncating divide, sat).
// ---------------------------------------------------------------------------
module tb_trilateration_2d_solver;
  import tri2d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 700;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  tri_in_t          item = '0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic             strobe;
  tri_out_t         result;

  logic [15:0] anchor_reg [NUM_REGS];
  tri_out_t    fix_queue [$];
  int          fail_count = 0;

  trilateration_2d_solver i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  always #2 clk = ~clk;

  initial begin
    #50ms;
    $display("trilateration_2d_solver regression: fail");
    $finish;
  end

  function automatic logic signed [63:0] coord(input logic [15:0] v);
    logic signed [CB-1:0] s;
    s = v[CB-1:0];
    return 64'(s);
  endfunction

  // trunc(num * 2^FB / den), saturated to 32 bits
  function automatic logic [31:0] fixed_quot(input logic signed [159:0] num,
                                             input logic signed [159:0] den);
    logic signed [159:0] q;
    q = (num <<< FB) / den;
    if (q > 160'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -160'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic tri_out_t predict_fix(input tri_in_t rg);
    logic signed [159:0] ax, ay, bx, by, cx, cy, ra, rb, rc;
    logic signed [159:0] t1, s2, t2, dab, dbc, dba, d, ny;
    tri_out_t o;
    ax = coord(anchor_reg[REG_AX]); ay = coord(anchor_reg[REG_AY]);
    bx = coord(anchor_reg[REG_BX]); by = coord(anchor_reg[REG_BY]);
    cx = coord(anchor_reg[REG_CX]); cy = coord(anchor_reg[REG_CY]);
    ra = {144'd0, rg.range_to_a}; rb = {144'd0, rg.range_to_b};
    rc = {144'd0, rg.range_to_c};
    t1 = -bx*bx - by*by + rb*rb;
    s2 = cx*cx + t1 + cy*cy - rc*rc;
    t2 = ax*ax + t1 + ay*ay - ra*ra;
    dab = ay - by; dbc = bx - cx; dba = bx - ax;
    d = dab*dbc - (cy - by)*dba;
    ny = t2*dbc - s2*dba;
    o.y_failed = (d == 0);
    o.x_failed = (dba == 0);
    o.pos_y = o.y_failed ? -(32'sd1 <<< FB) : fixed_quot(ny, 2*d);
    if (o.x_failed) o.pos_x = -(32'sd1 <<< FB);
    else if (o.y_failed) o.pos_x = fixed_quot(-2*dab - t2, 2*dba);
    else o.pos_x = fixed_quot(ny*dab - t2*d, 2*d*dba);
    return o;
  endfunction

  task automatic write_anchor(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < NUM_REGS) anchor_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_anchors(input logic [15:0] v [NUM_REGS]);
    foreach (v[i]) write_anchor(IDX_W'(i), v[i]);
  endtask

  // leaves start high so that beats can follow back to back
  task automatic send_ranges(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c);
    tri_in_t beat;
    beat.range_to_a = a; beat.range_to_b = b; beat.range_to_c = c;
    start <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    fix_queue.push_back(predict_fix(beat));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (fix_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int n, input int rmax);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        send_ranges(16'($urandom_range(0, rmax)), 16'($urandom_range(0, rmax)),
                    16'($urandom_range(0, rmax)));
        burst--; n--;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    tri_out_t want;
    if (!rst && strobe) begin
      if (fix_queue.size() == 0) begin
        $error("fix with nothing expected");
        fail_count++;
      end else begin
        want = fix_queue.pop_front();
        if (result.pos_x !== want.pos_x) begin
          $error("pos_x exp %0d got %0d", want.pos_x, result.pos_x); fail_count++;
        end
        if (result.pos_y !== want.pos_y) begin
          $error("pos_y exp %0d got %0d", want.pos_y, result.pos_y); fail_count++;
        end
        if (result.x_failed !== want.x_failed) begin
          $error("x_failed exp %0b got %0b", want.x_failed, result.x_failed);
          fail_count++;
        end
        if (result.y_failed !== want.y_failed) begin
          $error("y_failed exp %0b got %0b", want.y_failed, result.y_failed);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_anchors();
    // all anchors at origin: both denominators zero
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'hFFFF, 16'd1, 16'h8000);
    drain();
  endtask

  task automatic test_directed_geometry();
    logic [15:0] v [NUM_REGS];
    v = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100};
    load_anchors(v);
    send_ranges(16'd50, 16'd50, 16'd50);
    send_ranges(16'd0, 16'd100, 16'd100);
    send_ranges(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_ranges(16'hFFFF, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hFFFF, 16'hAAAA);
    drain();
    // ax == bx: x fails, y valid
    v = '{16'd5, 16'd0, 16'd5, 16'd40, 16'hFFF0, 16'd7};
    load_anchors(v);
    send_ranges(16'd20, 16'd30, 16'd25);
    send_ranges(16'd0, 16'h5555, 16'd1);
    drain();
    // collinear anchors: y fails, x from y = -1
    v = '{16'd0, 16'd0, 16'd10, 16'd10, 16'd20, 16'd20};
    load_anchors(v);
    send_ranges(16'd7, 16'd3, 16'd9);
    send_ranges(16'hFFFF, 16'd0, 16'hFFFF);
    drain();
    // extremes of the coordinate range, saturation
    v = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
    load_anchors(v);
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'hFFFF, 16'hFFFF, 16'd0);
    send_ranges(16'd1, 16'hFFFF, 16'h8000);
    drain();
    v = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1};
    load_anchors(v);
    send_ranges(16'hFFFF, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hFFFF, 16'hFFFF);
    drain();
    // out-of-range index is ignored
    write_anchor(3'd7, 16'h1234);
    write_anchor(3'd6, 16'hBEEF);
    send_ranges(16'd3, 16'd4, 16'd5);
    drain();
  endtask

  task automatic test_random_fixes();
    logic [15:0] v [NUM_REGS];
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      foreach (v[i]) begin
        case (phase % 4)
          0: v[i] = 16'($urandom_range(0, 200) - 100);
          1: v[i] = 16'($urandom);
          default: v[i] = 16'($urandom_range(0, 4000) - 2000);
        endcase
      end
      if (phase == 5) v[REG_BX] = v[REG_AX];
      if (phase == 6) begin
        v[REG_CX] = v[REG_BX]; v[REG_CY] = v[REG_BY];
      end
      load_anchors(v);
      send_random(125, (phase % 4 == 1) ? 65535 : 3000);
      drain();
    end
  endtask

  initial begin
    foreach (anchor_reg[i]) anchor_reg[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_anchors();
    test_directed_geometry();
    test_random_fixes();
    if (fail_count == 0) $display("trilateration_2d_solver regression: pass");
    else $display("trilateration_2d_solver regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tri2d_pkg.sv
design/tri2d_div.sv
design/tri2d_front.sv
design/trilateration_2d_solver.sv
design/tri2d_checker.sv
tb/tb_trilateration_2d_solver.sv
